FILE: hdl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants for the sparse column-to-row transpose block.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int MAX_ROWS     = 256;
    localparam int MAX_COLS     = 256;
    localparam int MAX_NZ       = 1024;
    localparam int ROW_W        = 8;
    localparam int COL_W        = 8;
    localparam int NZ_AW        = 10;
    localparam int CNT_W        = 11;
    localparam int DIM_W        = 9;
    localparam int VAL_W        = 64;
    localparam int RS_DEPTH     = MAX_ROWS + 1;
    localparam int RS_AW        = 9;

    typedef enum logic [2:0] {
        REQ_CLEAR      = 3'd0,
        REQ_APPEND     = 3'd1,
        REQ_FINISH     = 3'd2,
        REQ_READ_PTR   = 3'd3,
        REQ_READ_ENTRY = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_FULL     = 3'd1,
        STS_COL_BAD  = 3'd2,
        STS_ROW_BAD  = 3'd3,
        STS_READ_BAD = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        RK_NONE,
        RK_PTR,
        RK_ENTRY
    } resp_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APP_WR,
        ST_PS_RD,
        ST_PS_WR,
        ST_PS_END,
        ST_SC_SRC,
        ST_SC_CUR,
        ST_SC_WR,
        ST_RESP
    } state_t;

    localparam logic [1:0] CFG_NUM_ROWS = 2'd0;
    localparam logic [1:0] CFG_NUM_COLS = 2'd1;

    typedef struct packed {
        logic               cnt_rd_en;
        logic               cnt_we;
        logic [ROW_W-1:0]   cnt_addr;
        logic [CNT_W-1:0]   cnt_wdata;
        logic               src_rd_en;
        logic               src_we;
        logic [NZ_AW-1:0]   src_addr;
        logic [ROW_W-1:0]   src_row;
        logic [COL_W-1:0]   src_col;
        logic [VAL_W-1:0]   src_val;
        logic               rs_rd_en;
        logic               rs_we;
        logic [RS_AW-1:0]   rs_addr;
        logic [CNT_W-1:0]   rs_wdata;
        logic               cur_rd_en;
        logic               cur_we;
        logic [ROW_W-1:0]   cur_addr;
        logic [CNT_W-1:0]   cur_wdata;
        logic               dst_rd_en;
        logic               dst_we;
        logic [NZ_AW-1:0]   dst_addr;
        logic [COL_W-1:0]   dst_col;
        logic [VAL_W-1:0]   dst_val;
    } mem_ctl_t;

    typedef struct packed {
        logic [CNT_W-1:0]   cnt_rd;
        logic [ROW_W-1:0]   src_row_rd;
        logic [COL_W-1:0]   src_col_rd;
        logic [VAL_W-1:0]   src_val_rd;
        logic [CNT_W-1:0]   rs_rd;
        logic [CNT_W-1:0]   cur_rd;
        logic [COL_W-1:0]   dst_col_rd;
        logic [VAL_W-1:0]   dst_val_rd;
    } mem_rd_t;

    typedef struct packed {
        logic [VAL_W-1:0]   value;
        logic [COL_W-1:0]   column;
        logic [CNT_W-1:0]   row_pointer;
        logic [2:0]         status;
    } result_t;

endpackage

FILE: hdl/sct_mem.sv
// ----------------------------------------------------------------------------
// sct_mem
// Synchronous storage: row counts, source entries, row starts, row cursors
// and transposed entries. Every memory has a registered read.
// ----------------------------------------------------------------------------
module sct_mem
    import sct_pkg::*;
(
    input  logic     clk,
    input  mem_ctl_t ctl,
    output mem_rd_t  rd
);

    logic [CNT_W-1:0] cnt_mem  [0:MAX_ROWS-1];
    logic [ROW_W-1:0] srow_mem [0:MAX_NZ-1];
    logic [COL_W-1:0] scol_mem [0:MAX_NZ-1];
    logic [VAL_W-1:0] sval_mem [0:MAX_NZ-1];
    logic [CNT_W-1:0] rs_mem   [0:RS_DEPTH-1];
    logic [CNT_W-1:0] cur_mem  [0:MAX_ROWS-1];
    logic [COL_W-1:0] dcol_mem [0:MAX_NZ-1];
    logic [VAL_W-1:0] dval_mem [0:MAX_NZ-1];

    logic [CNT_W-1:0] cnt_rd_reg;
    logic [ROW_W-1:0] src_row_rd_reg;
    logic [COL_W-1:0] src_col_rd_reg;
    logic [VAL_W-1:0] src_val_rd_reg;
    logic [CNT_W-1:0] rs_rd_reg;
    logic [CNT_W-1:0] cur_rd_reg;
    logic [COL_W-1:0] dst_col_rd_reg;
    logic [VAL_W-1:0] dst_val_rd_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.cnt_we)
        begin
            cnt_mem[ctl.cnt_addr] <= ctl.cnt_wdata;
        end
        if (ctl.cnt_rd_en)
        begin
            cnt_rd_reg <= cnt_mem[ctl.cnt_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.src_we)
        begin
            srow_mem[ctl.src_addr] <= ctl.src_row;
            scol_mem[ctl.src_addr] <= ctl.src_col;
            sval_mem[ctl.src_addr] <= ctl.src_val;
        end
        if (ctl.src_rd_en)
        begin
            src_row_rd_reg <= srow_mem[ctl.src_addr];
            src_col_rd_reg <= scol_mem[ctl.src_addr];
            src_val_rd_reg <= sval_mem[ctl.src_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rs_we)
        begin
            rs_mem[ctl.rs_addr] <= ctl.rs_wdata;
        end
        if (ctl.rs_rd_en)
        begin
            rs_rd_reg <= rs_mem[ctl.rs_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cur_we)
        begin
            cur_mem[ctl.cur_addr] <= ctl.cur_wdata;
        end
        if (ctl.cur_rd_en)
        begin
            cur_rd_reg <= cur_mem[ctl.cur_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.dst_we)
        begin
            dcol_mem[ctl.dst_addr] <= ctl.dst_col;
            dval_mem[ctl.dst_addr] <= ctl.dst_val;
        end
        if (ctl.dst_rd_en)
        begin
            dst_col_rd_reg <= dcol_mem[ctl.dst_addr];
            dst_val_rd_reg <= dval_mem[ctl.dst_addr];
        end
    end

    always_comb
    begin
        rd.cnt_rd     = cnt_rd_reg;
        rd.src_row_rd = src_row_rd_reg;
        rd.src_col_rd = src_col_rd_reg;
        rd.src_val_rd = src_val_rd_reg;
        rd.rs_rd      = rs_rd_reg;
        rd.cur_rd     = cur_rd_reg;
        rd.dst_col_rd = dst_col_rd_reg;
        rd.dst_val_rd = dst_val_rd_reg;
    end

endmodule

FILE: hdl/sct_ctrl.sv
// ----------------------------------------------------------------------------
// sct_ctrl
// Request sequencer: append checks, row count updates, prefix sum, scatter
// and the result register.
// ----------------------------------------------------------------------------
module sct_ctrl
    import sct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DIM_W-1:0] eff_rows,
    input  logic [DIM_W-1:0] eff_cols,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       in_req,
    input  logic [ROW_W-1:0] in_row,
    input  logic [COL_W-1:0] in_col,
    input  logic [VAL_W-1:0] in_val,
    input  logic [CNT_W-1:0] in_ridx,
    output logic             out_valid,
    input  logic             out_ready,
    output result_t          out_res,
    output mem_ctl_t         mem_ctl,
    input  mem_rd_t          mem_rd
);

    state_t               state_reg, state_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [CNT_W-1:0]     entry_count_reg, entry_count_next;
    logic [COL_W-1:0]     last_col_reg, last_col_next;
    logic                 done_reg, done_next;
    logic [MAX_ROWS-1:0]  cnt_valid_reg, cnt_valid_next;
    logic [ROW_W-1:0]     r_reg, r_next;
    logic [CNT_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    status_t              status_reg, status_next;
    resp_kind_t           kind_reg, kind_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              res_reg, res_next;

    logic                 out_free;
    logic                 accept;
    logic                 append_ok;
    status_t              append_sts;
    logic [CNT_W-1:0]     cnt_cur;
    logic [CNT_W-1:0]     k_inc;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;
    assign k_inc     = k_reg + CNT_W'(1);
    // count read back for the row being updated or summed
    assign cnt_cur   = cnt_valid_reg[(state_reg == ST_PS_WR) ? r_reg : row_reg] ?
                       mem_rd.cnt_rd : '0;

    // append checks run in priority order
    always_comb
    begin
        append_ok  = 1'b0;
        append_sts = STS_OK;
        priority if (done_reg)
            append_sts = STS_READ_BAD;
        else if (entry_count_reg == CNT_W'(MAX_NZ))
            append_sts = STS_FULL;
        else if ({1'b0, in_col} >= eff_cols || in_col < last_col_reg)
            append_sts = STS_COL_BAD;
        else if ({1'b0, in_row} >= eff_rows)
            append_sts = STS_ROW_BAD;
        else
            append_ok = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_req == REQ_APPEND && append_ok)
                        state_next = ST_APP_WR;
                    else if (in_req == REQ_FINISH)
                        state_next = ST_PS_RD;
                    else
                        state_next = ST_RESP;
                end
            end
            ST_APP_WR: state_next = ST_RESP;
            ST_PS_RD:  state_next = ST_PS_WR;
            ST_PS_WR:  state_next = (r_reg == ROW_W'(MAX_ROWS - 1)) ? ST_PS_END : ST_PS_RD;
            ST_PS_END: state_next = (entry_count_reg == '0) ? ST_RESP : ST_SC_SRC;
            ST_SC_SRC: state_next = ST_SC_CUR;
            ST_SC_CUR: state_next = ST_SC_WR;
            ST_SC_WR:  state_next = (k_inc == entry_count_reg) ? ST_RESP : ST_SC_SRC;
            ST_RESP:   state_next = out_free ? ST_IDLE : ST_RESP;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        row_next         = row_reg;
        col_next         = col_reg;
        entry_count_next = entry_count_reg;
        last_col_next    = last_col_reg;
        done_next        = done_reg;
        cnt_valid_next   = cnt_valid_reg;
        r_next           = r_reg;
        sum_next         = sum_reg;
        k_next           = k_reg;
        status_next      = status_reg;
        kind_next        = kind_reg;
        out_valid_next   = out_valid_reg;
        res_next         = res_reg;
        mem_ctl          = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                row_next    = in_row;
                col_next    = in_col;
                kind_next   = RK_NONE;
                status_next = STS_OK;
                mem_ctl.cnt_addr = in_row;
                if (accept)
                begin
                    unique case (in_req)
                        REQ_CLEAR:
                        begin
                            entry_count_next = '0;
                            last_col_next    = '0;
                            done_next        = 1'b0;
                            cnt_valid_next   = '0;
                        end
                        REQ_APPEND:
                        begin
                            status_next = append_sts;
                            if (append_ok)
                            begin
                                mem_ctl.src_we    = 1'b1;
                                mem_ctl.src_addr  = entry_count_reg[NZ_AW-1:0];
                                mem_ctl.src_row   = in_row;
                                mem_ctl.src_col   = in_col;
                                mem_ctl.src_val   = in_val;
                                mem_ctl.cnt_rd_en = 1'b1;
                            end
                        end
                        REQ_FINISH:
                        begin
                            r_next   = '0;
                            sum_next = '0;
                        end
                        REQ_READ_PTR:
                        begin
                            if (!done_reg || in_ridx > {2'b00, eff_rows})
                                status_next = STS_READ_BAD;
                            else
                            begin
                                kind_next        = RK_PTR;
                                mem_ctl.rs_rd_en = 1'b1;
                                mem_ctl.rs_addr  = in_ridx[RS_AW-1:0];
                            end
                        end
                        REQ_READ_ENTRY:
                        begin
                            if (!done_reg || in_ridx >= entry_count_reg)
                                status_next = STS_READ_BAD;
                            else
                            begin
                                kind_next         = RK_ENTRY;
                                mem_ctl.dst_rd_en = 1'b1;
                                mem_ctl.dst_addr  = in_ridx[NZ_AW-1:0];
                            end
                        end
                        default: status_next = STS_READ_BAD;
                    endcase
                end
            end
            ST_APP_WR:
            begin
                mem_ctl.cnt_addr       = row_reg;
                mem_ctl.cnt_we         = 1'b1;
                mem_ctl.cnt_wdata      = cnt_cur + CNT_W'(1);
                cnt_valid_next[row_reg] = 1'b1;
                last_col_next          = col_reg;
                entry_count_next       = entry_count_reg + CNT_W'(1);
            end
            ST_PS_RD:
            begin
                mem_ctl.cnt_rd_en = 1'b1;
                mem_ctl.cnt_addr  = r_reg;
            end
            ST_PS_WR:
            begin
                mem_ctl.cnt_addr  = r_reg;
                mem_ctl.rs_we     = 1'b1;
                mem_ctl.rs_addr   = {1'b0, r_reg};
                mem_ctl.rs_wdata  = sum_reg;
                mem_ctl.cur_we    = 1'b1;
                mem_ctl.cur_addr  = r_reg;
                mem_ctl.cur_wdata = sum_reg;
                sum_next          = sum_reg + cnt_cur;
                r_next            = r_reg + ROW_W'(1);
            end
            ST_PS_END:
            begin
                // closing pointer holds the total count
                mem_ctl.rs_we    = 1'b1;
                mem_ctl.rs_addr  = RS_AW'(MAX_ROWS);
                mem_ctl.rs_wdata = sum_reg;
                k_next           = '0;
                done_next        = 1'b1;
            end
            ST_SC_SRC:
            begin
                mem_ctl.src_rd_en = 1'b1;
                mem_ctl.src_addr  = k_reg[NZ_AW-1:0];
            end
            ST_SC_CUR:
            begin
                mem_ctl.cur_rd_en = 1'b1;
                mem_ctl.cur_addr  = mem_rd.src_row_rd;
            end
            ST_SC_WR:
            begin
                // place entry at the row cursor, then advance the cursor
                mem_ctl.dst_we    = 1'b1;
                mem_ctl.dst_addr  = mem_rd.cur_rd[NZ_AW-1:0];
                mem_ctl.dst_col   = mem_rd.src_col_rd;
                mem_ctl.dst_val   = mem_rd.src_val_rd;
                mem_ctl.cur_we    = 1'b1;
                mem_ctl.cur_addr  = mem_rd.src_row_rd;
                mem_ctl.cur_wdata = mem_rd.cur_rd + CNT_W'(1);
                k_next            = k_inc;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    res_next.status      = status_reg;
                    res_next.row_pointer = (kind_reg == RK_PTR) ? mem_rd.rs_rd : '0;
                    res_next.column      = (kind_reg == RK_ENTRY) ? mem_rd.dst_col_rd : '0;
                    res_next.value       = (kind_reg == RK_ENTRY) ? mem_rd.dst_val_rd : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            last_col_reg    <= '0;
            done_reg        <= 1'b0;
            cnt_valid_reg   <= '0;
            out_valid_reg   <= 1'b0;
            r_reg           <= '0;
            sum_reg         <= '0;
            k_reg           <= '0;
            status_reg      <= STS_OK;
            kind_reg        <= RK_NONE;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            last_col_reg    <= last_col_next;
            done_reg        <= done_next;
            cnt_valid_reg   <= cnt_valid_next;
            out_valid_reg   <= out_valid_next;
            r_reg           <= r_next;
            sum_reg         <= sum_next;
            k_reg           <= k_next;
            status_reg      <= status_next;
            kind_reg        <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        col_reg <= col_next;
        res_reg <= res_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(MAX_NZ))
        else $error("entry count beyond store depth");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(state_reg == ST_PS_END))
        else $error("done set outside finish");

    a_append_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APP_WR) |-> (!done_reg && entry_count_reg < CNT_W'(MAX_NZ)))
        else $error("append committed while not allowed");

    a_scatter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SC_WR) |=> (k_reg <= entry_count_reg))
        else $error("scatter ran past entry count");

endmodule

FILE: hdl/sparse_csc_transpose.sv
// ----------------------------------------------------------------------------
// sparse_csc_transpose
// Compressed sparse column transpose with stream request/result ports and an
// APB register port for the matrix dimensions.
// ----------------------------------------------------------------------------
// Clear, errors and append-errors go straight to the result register; an
//   append updates the row count first; reads use a registered memory read.
// Finish: a prefix sum over the row count memory (read, then write per row),
//   then the closing pointer, then the scatter for each stored entry
//   (source read, cursor read, write-back).
// One request in flight; the next is taken once the result is in the output
//   register. Reset clears counts, flags and state; memories keep contents.
module sparse_csc_transpose
    import sct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // req_type[2:0], row_index[10:3], col_index[18:11], entry_value[82:19],
    // read_index[93:83], zero pad[95:94]
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], row_pointer[13:3], out_column[21:14], out_value[85:22],
    // zero pad[87:86]
    output logic [87:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [DIM_W-1:0] num_rows_reg;
    logic [DIM_W-1:0] num_cols_reg;
    logic [DIM_W-1:0] eff_rows;
    logic [DIM_W-1:0] eff_cols;
    logic             cfg_wr;
    logic [1:0]       cfg_idx;
    result_t          res;
    mem_ctl_t         mem_ctl;
    mem_rd_t          mem_rd;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = {1'b0, paddr[2]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= DIM_W'(MAX_ROWS);
            num_cols_reg <= DIM_W'(MAX_COLS);
        end
        else if (cfg_wr)
        begin
            if (cfg_idx == CFG_NUM_ROWS)
                num_rows_reg <= pwdata[DIM_W-1:0];
            else
                num_cols_reg <= pwdata[DIM_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_idx == CFG_NUM_ROWS)
            prdata[DIM_W-1:0] = num_rows_reg;
        else
            prdata[DIM_W-1:0] = num_cols_reg;
    end

    // clamp dimensions to the storage limits
    assign eff_rows = (num_rows_reg > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : num_rows_reg;
    assign eff_cols = (num_cols_reg > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : num_cols_reg;

    sct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .eff_rows  (eff_rows),
        .eff_cols  (eff_cols),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tdata[2:0]),
        .in_row    (s_tdata[10:3]),
        .in_col    (s_tdata[18:11]),
        .in_val    (s_tdata[82:19]),
        .in_ridx   (s_tdata[93:83]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .mem_ctl   (mem_ctl),
        .mem_rd    (mem_rd)
    );

    sct_mem u_mem (
        .clk (clk),
        .ctl (mem_ctl),
        .rd  (mem_rd)
    );

    assign m_tdata = {2'b00, res};

endmodule
